// ===== rtl/plom_pkg.sv =====
// Package for the price level order matcher.
// Holds sizes, outcome codes, controller states and the control/status structs.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plom_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int FILL_W = $clog2(MAX_RESULTS + 1);

    localparam int PRICE_W = 32;
    localparam int SHARE_W = 24;
    localparam int ID_W    = 32;
    localparam int CODE_W  = 3;
    localparam int VOL_W   = 28;

    localparam logic [CODE_W-1:0] OUT_NONE     = 3'd0;
    localparam logic [CODE_W-1:0] OUT_FILLED   = 3'd1;
    localparam logic [CODE_W-1:0] OUT_EMPTIED  = 3'd2;
    localparam logic [CODE_W-1:0] OUT_BOTH     = 3'd3;
    localparam logic [CODE_W-1:0] OUT_ADDED    = 3'd4;
    localparam logic [CODE_W-1:0] OUT_REJECTED = 3'd5;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_MATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic              ready;       // take a new item
        logic              add;         // write the held item at the tail
        logic              emit;        // send a result without a fill, marked last
        logic [CODE_W-1:0] code;        // outcome of that result
        logic              latch_code;  // hold the outcome of a crossing order
        logic              fill;        // fill against the head entry and send the trade
        logic              finish;      // end of a match: clear the level if emptied
    } cmd_t;

    typedef struct packed {
        logic              in_take;
        logic              action;
        logic              add_ok;
        logic              crosses;
        logic              fill_none;
        logic              fill_last;
        logic              out_free;
        logic [CODE_W-1:0] held_code;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/plom_if.sv =====
// Channel interfaces for the order matcher: incoming orders and trade results.
// Depends on plom_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface plom_order_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic                            buy_side;
    logic [plom_pkg::PRICE_W-1:0]    limit_price;
    logic [plom_pkg::SHARE_W-1:0]    order_shares;
    logic [plom_pkg::ID_W-1:0]       order_id;

    modport source (output valid, action, buy_side, limit_price, order_shares, order_id,
                    input ready);
    modport sink   (input valid, action, buy_side, limit_price, order_shares, order_id,
                    output ready);
endinterface

interface plom_trade_if;
    logic                            valid;
    logic                            ready;
    logic [plom_pkg::ID_W-1:0]       taker_id;
    logic [plom_pkg::ID_W-1:0]       maker_id;
    logic [plom_pkg::SHARE_W-1:0]    matched_shares;
    logic [plom_pkg::CODE_W-1:0]     outcome;
    logic                            last;

    modport source (output valid, taker_id, maker_id, matched_shares, outcome, last,
                    input ready);
    modport sink   (input valid, taker_id, maker_id, matched_shares, outcome, last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/plom_ctrl.sv =====
// Controller state machine of the order matcher.
// Depends on plom_pkg; drives the datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps
`default_nettype none

module plom_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire plom_pkg::status_t status,
    output plom_pkg::cmd_t         cmd
);

    plom_pkg::state_t state_reg;
    plom_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plom_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.code       = plom_pkg::OUT_NONE;
        case (state_reg)
            plom_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (status.in_take)
                begin
                    state_next = plom_pkg::ST_EVAL;
                end
            end
            plom_pkg::ST_EVAL:
            begin
                if (status.action == plom_pkg::ACT_ADD)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.add    = status.add_ok;
                        cmd.code   = status.add_ok ? plom_pkg::OUT_ADDED
                                                   : plom_pkg::OUT_REJECTED;
                        state_next = plom_pkg::ST_IDLE;
                    end
                end
                else if (!status.crosses)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = plom_pkg::OUT_NONE;
                        state_next = plom_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.latch_code = 1'b1;
                    state_next     = plom_pkg::ST_FILL;
                end
            end
            plom_pkg::ST_FILL:
            begin
                if (status.out_free)
                begin
                    if (status.fill_none)
                    begin
                        // crossing order with nothing to fill
                        cmd.emit   = 1'b1;
                        cmd.code   = status.held_code;
                        cmd.finish = 1'b1;
                        state_next = plom_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.fill = 1'b1;
                        if (status.fill_last)
                        begin
                            cmd.finish = 1'b1;
                            state_next = plom_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = plom_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/plom_dp.sv =====
// Datapath of the order matcher: level price, held item, resting order FIFO,
// total volume, fill arithmetic and the result register. Depends on plom_pkg, plom_if.
`timescale 1ns / 1ps
`default_nettype none

module plom_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [plom_pkg::PRICE_W-1:0]  cfg_data,
    plom_order_if.sink                         orders,
    plom_trade_if.source                       trades,
    input  wire plom_pkg::cmd_t                cmd,
    output plom_pkg::status_t                  status
);

    logic [plom_pkg::PRICE_W-1:0] level_price_reg;

    logic                         act_reg;
    logic                         buy_reg;
    logic [plom_pkg::PRICE_W-1:0] lim_reg;
    logic [plom_pkg::SHARE_W-1:0] shares_reg;
    logic [plom_pkg::ID_W-1:0]    id_reg;
    logic [plom_pkg::CODE_W-1:0]  code_reg;
    logic [plom_pkg::FILL_W-1:0]  fills_reg;

    logic [plom_pkg::IDX_W-1:0]   head_reg;
    logic [plom_pkg::CNT_W-1:0]   count_reg;
    logic [plom_pkg::VOL_W-1:0]   vol_reg;

    logic [plom_pkg::SHARE_W-1:0] rest_shares [plom_pkg::QUEUE_DEPTH];
    logic [plom_pkg::ID_W-1:0]    rest_ids    [plom_pkg::QUEUE_DEPTH];
    logic [plom_pkg::SHARE_W-1:0] have_reg;

    logic                         out_valid_reg;
    logic [plom_pkg::ID_W-1:0]    taker_reg;
    logic [plom_pkg::ID_W-1:0]    maker_reg;
    logic [plom_pkg::SHARE_W-1:0] qty_reg;
    logic [plom_pkg::CODE_W-1:0]  outcome_reg;
    logic                         last_reg;

    logic [plom_pkg::SHARE_W-1:0] have;
    logic [plom_pkg::SHARE_W-1:0] qty;
    logic [plom_pkg::SHARE_W-1:0] shares_left;
    logic                         drained;
    logic [plom_pkg::IDX_W-1:0]   head_inc;
    logic [plom_pkg::IDX_W-1:0]   rd_addr;
    logic [plom_pkg::SUM_W-1:0]   tail_sum;
    logic [plom_pkg::IDX_W-1:0]   tail;
    logic [plom_pkg::VOL_W:0]     vol_sum;
    logic [plom_pkg::VOL_W-1:0]   vol_add;
    logic [plom_pkg::VOL_W-1:0]   vol_sub;
    logic [plom_pkg::VOL_W-1:0]   shares_wide;
    logic [plom_pkg::CODE_W-1:0]  code_calc;
    logic                         crosses;
    logic                         out_free;
    logic                         clear_now;

    assign out_free = !out_valid_reg || trades.ready;

    assign have        = have_reg;
    assign qty         = (shares_reg < have) ? shares_reg : have;
    assign shares_left = shares_reg - qty;
    assign drained     = (have == qty);
    assign head_inc    = (head_reg == plom_pkg::IDX_W'(plom_pkg::QUEUE_DEPTH - 1))
                         ? '0 : head_reg + 1'b1;
    // read ahead at the next head when the current one drains
    assign rd_addr     = (cmd.fill && drained) ? head_inc : head_reg;

    assign tail_sum = plom_pkg::SUM_W'(head_reg) + plom_pkg::SUM_W'(count_reg);
    assign tail     = (tail_sum >= plom_pkg::SUM_W'(plom_pkg::QUEUE_DEPTH))
                      ? plom_pkg::IDX_W'(tail_sum - plom_pkg::SUM_W'(plom_pkg::QUEUE_DEPTH))
                      : plom_pkg::IDX_W'(tail_sum);

    assign shares_wide = plom_pkg::VOL_W'(shares_reg);
    assign vol_sum     = {1'b0, vol_reg} + {1'b0, shares_wide};
    assign vol_add     = vol_sum[plom_pkg::VOL_W] ? '1 : vol_sum[plom_pkg::VOL_W-1:0];
    assign vol_sub     = (vol_reg > plom_pkg::VOL_W'(qty))
                         ? vol_reg - plom_pkg::VOL_W'(qty) : '0;

    assign crosses = buy_reg ? (lim_reg >= level_price_reg) : (lim_reg <= level_price_reg);

    always_comb
    begin
        if (shares_wide == vol_reg)
        begin
            code_calc = plom_pkg::OUT_BOTH;
        end
        else if (shares_wide < vol_reg)
        begin
            code_calc = plom_pkg::OUT_FILLED;
        end
        else
        begin
            code_calc = plom_pkg::OUT_EMPTIED;
        end
    end

    assign clear_now = cmd.finish &&
                       (code_reg == plom_pkg::OUT_EMPTIED || code_reg == plom_pkg::OUT_BOTH);

    assign orders.ready = cmd.ready;

    always_comb
    begin
        status           = '0;
        status.in_take   = orders.valid && cmd.ready;
        status.action    = act_reg;
        status.add_ok    = (count_reg < plom_pkg::CNT_W'(plom_pkg::QUEUE_DEPTH)) &&
                           (shares_reg != '0);
        status.crosses   = crosses;
        status.fill_none = (shares_reg == '0) || (count_reg == '0);
        status.fill_last = (shares_left == '0) ||
                           (drained && count_reg == plom_pkg::CNT_W'(1)) ||
                           (fills_reg == plom_pkg::FILL_W'(plom_pkg::MAX_RESULTS - 1));
        status.out_free  = out_free;
        status.held_code = code_reg;
    end

    // level price register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_price_reg <= '0;
        end
        else if (cfg_we)
        begin
            level_price_reg <= cfg_data;
        end
    end

    // held item; shares count down as fills go out
    always_ff @(posedge clk)
    begin
        if (cmd.ready && orders.valid)
        begin
            act_reg    <= orders.action;
            buy_reg    <= orders.buy_side;
            lim_reg    <= orders.limit_price;
            shares_reg <= orders.order_shares;
            id_reg     <= orders.order_id;
            fills_reg  <= '0;
        end
        else if (cmd.fill)
        begin
            shares_reg <= shares_left;
            fills_reg  <= fills_reg + 1'b1;
        end
        if (cmd.latch_code)
        begin
            code_reg <= code_calc;
        end
    end

    // FIFO pointers and total volume
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            vol_reg   <= '0;
        end
        else if (clear_now)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            vol_reg   <= '0;
        end
        else if (cmd.add)
        begin
            count_reg <= count_reg + 1'b1;
            vol_reg   <= vol_add;
        end
        else if (cmd.fill)
        begin
            vol_reg <= vol_sub;
            if (drained)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // resting order storage
    always_ff @(posedge clk)
    begin
        if (cmd.add)
        begin
            rest_shares[tail] <= shares_reg;
            rest_ids[tail]    <= id_reg;
        end
        else if (cmd.fill)
        begin
            rest_shares[head_reg] <= have - qty;
        end
        have_reg <= rest_shares[rd_addr];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.fill)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (trades.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            taker_reg   <= id_reg;
            maker_reg   <= '0;
            qty_reg     <= '0;
            outcome_reg <= cmd.code;
            last_reg    <= 1'b1;
        end
        else if (cmd.fill)
        begin
            taker_reg   <= id_reg;
            maker_reg   <= rest_ids[head_reg];
            qty_reg     <= qty;
            outcome_reg <= status.fill_last ? code_reg : plom_pkg::OUT_NONE;
            last_reg    <= status.fill_last;
        end
    end

    assign trades.valid          = out_valid_reg;
    assign trades.taker_id       = taker_reg;
    assign trades.maker_id       = maker_reg;
    assign trades.matched_shares = qty_reg;
    assign trades.outcome        = outcome_reg;
    assign trades.last           = last_reg;

endmodule

`default_nettype wire

// ===== rtl/price_level_order_matcher_top.sv =====
// Price level order matcher: one item at a time. An item is taken in ST_IDLE and
// evaluated in ST_EVAL; add, reject and no-cross items post their result there once
// the output register is free. A crossing order then fills in ST_FILL, one result per
// fill and at most MAX_RESULTS, or posts a single result if nothing can be filled.
// Results sit in an output register; the next item may be taken while one waits.
// Reset (asynchronous, active low) empties the level and clears level_price to 0.
`timescale 1ns / 1ps
`default_nettype none

module price_level_order_matcher_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [plom_pkg::PRICE_W-1:0]  cfg_data,
    plom_order_if.sink                         orders,
    plom_trade_if.source                       trades
);

    plom_pkg::cmd_t    cmd;
    plom_pkg::status_t status;

    plom_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    plom_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .orders   (orders),
        .trades   (trades),
        .cmd      (cmd),
        .status   (status)
    );

    // a result that is not the last of its item is always a real fill
    a_mid_is_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (trades.valid && !trades.last) |->
            (trades.matched_shares != '0 && trades.outcome == plom_pkg::OUT_NONE))
        else $error("non-last result without a fill");

    // only one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (orders.valid && orders.ready) |=> !orders.ready)
        else $error("item taken while another is in work");

    // fill only when there is something to fill
    a_fill_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> (!status.fill_none && status.out_free))
        else $error("fill issued with nothing to fill");

    // never emit and fill in the same cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit && cmd.fill))
        else $error("two results in one cycle");

endmodule

`default_nettype wire

// ===== bench/tb_price_level_order_matcher_top.sv =====
// Self-checking bench for price_level_order_matcher_top: drives order items, predicts
// every trade item from a local copy of the price level and checks each one on arrival.
// Depends on plom_pkg, plom_if (plom_order_if, plom_trade_if) and the top module.
`timescale 1ns / 1ps

module tb_price_level_order_matcher_top;
    import plom_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = MAX_RESULTS + 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 29;
    localparam int NUM_PHASES    = 5;
    localparam int PRINT_CAP     = 40;
    localparam logic [VOL_W-1:0] VOL_CEILING = '1;

    typedef struct packed {
        logic               action;
        logic               buy_side;
        logic [PRICE_W-1:0] limit_price;
        logic [SHARE_W-1:0] order_shares;
        logic [ID_W-1:0]    order_id;
    } order_t;

    typedef struct packed {
        logic [ID_W-1:0]    taker_id;
        logic [ID_W-1:0]    maker_id;
        logic [SHARE_W-1:0] matched_shares;
        logic [CODE_W-1:0]  outcome;
        logic               last;
    } trade_t;

    // Local copy of the price level and the trades it is due to emit.
    class price_level_book;
        logic [PRICE_W-1:0] level_price;
        logic [SHARE_W-1:0] rest_qty [QUEUE_DEPTH];
        logic [ID_W-1:0]    rest_owner [QUEUE_DEPTH];
        int                 head;
        int                 used;
        logic [VOL_W-1:0]   volume;
        trade_t             expected_trades [$];
        int                 mismatch_count;

        function new();
            level_price    = '0;
            head           = 0;
            used           = 0;
            volume         = '0;
            mismatch_count = 0;
        endfunction

        task report_mismatch(input string what);
            if (mismatch_count < PRINT_CAP)
                $display("MISMATCH at %0t: %0s", $realtime, what);
            mismatch_count++;
        endtask

        function void note_order(input order_t o);
            trade_t             t;
            logic [SHARE_W-1:0] left;
            logic [SHARE_W-1:0] qty;
            logic [CODE_W-1:0]  code;
            logic [VOL_W:0]     sum;
            int                 slot;
            int                 fills;
            t.taker_id       = o.order_id;
            t.maker_id       = '0;
            t.matched_shares = '0;
            t.outcome        = OUT_NONE;
            t.last           = 1'b1;
            fills            = 0;
            if (o.action == ACT_ADD)
            begin
                if (used >= QUEUE_DEPTH || o.order_shares == '0)
                    t.outcome = OUT_REJECTED;
                else
                begin
                    slot             = (head + used) % QUEUE_DEPTH;
                    rest_qty[slot]   = o.order_shares;
                    rest_owner[slot] = o.order_id;
                    used++;
                    sum    = {1'b0, volume} + o.order_shares;
                    volume = (sum > VOL_CEILING) ? VOL_CEILING : sum[VOL_W-1:0];
                    t.outcome = OUT_ADDED;
                end
                expected_trades.push_back(t);
            end
            else if (!((o.buy_side && o.limit_price >= level_price) ||
                       (!o.buy_side && o.limit_price <= level_price)))
            begin
                expected_trades.push_back(t);
            end
            else
            begin
                // outcome is decided against the volume before any fill
                if (o.order_shares == volume)
                    code = OUT_BOTH;
                else if (o.order_shares < volume)
                    code = OUT_FILLED;
                else
                    code = OUT_EMPTIED;
                left = o.order_shares;
                while (left != '0 && used != 0 && fills < MAX_RESULTS)
                begin
                    qty = (left < rest_qty[head]) ? left : rest_qty[head];
                    left           = left - qty;
                    rest_qty[head] = rest_qty[head] - qty;
                    volume         = (volume > qty) ? volume - qty : '0;
                    t.maker_id       = rest_owner[head];
                    t.matched_shares = qty;
                    t.outcome        = OUT_NONE;
                    t.last           = 1'b0;
                    expected_trades.push_back(t);
                    fills++;
                    if (rest_qty[head] == '0)
                    begin
                        head = (head + 1) % QUEUE_DEPTH;
                        used--;
                    end
                end
                if (code == OUT_EMPTIED || code == OUT_BOTH)
                begin
                    head   = 0;
                    used   = 0;
                    volume = '0;
                end
                if (fills == 0)
                begin
                    t.outcome = code;
                    expected_trades.push_back(t);
                end
                else
                begin
                    // the final fill carries the outcome
                    t         = expected_trades[expected_trades.size() - 1];
                    t.outcome = code;
                    t.last    = 1'b1;
                    expected_trades[expected_trades.size() - 1] = t;
                end
            end
        endfunction

        task check_trade(input trade_t got);
            trade_t want;
            if (expected_trades.size() == 0)
            begin
                report_mismatch($sformatf("trade with none due: taker %h maker %h",
                                          got.taker_id, got.maker_id));
            end
            else
            begin
                want = expected_trades.pop_front();
                if (got.taker_id !== want.taker_id)
                    report_mismatch($sformatf("taker_id %h, want %h",
                                              got.taker_id, want.taker_id));
                if (got.maker_id !== want.maker_id)
                    report_mismatch($sformatf("maker_id %h, want %h",
                                              got.maker_id, want.maker_id));
                if (got.matched_shares !== want.matched_shares)
                    report_mismatch($sformatf("matched_shares %h, want %h",
                                              got.matched_shares, want.matched_shares));
                if (got.outcome !== want.outcome)
                    report_mismatch($sformatf("outcome %0d, want %0d",
                                              got.outcome, want.outcome));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", got.last, want.last));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [PRICE_W-1:0] cfg_data;
    int                 sender_idle_pct;
    int                 receiver_stall_pct;
    int                 hold_left;
    int                 cycle_count;
    price_level_book    book;

    plom_order_if order_ch ();
    plom_trade_if trade_ch ();

    price_level_order_matcher_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .orders   (order_ch),
        .trades   (trade_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_price_level_order_matcher_top: done, errors");
            $finish;
        end
    end

    // Receiver: a requested hold-off wins over the random stall.
    initial
    begin
        trade_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                trade_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                trade_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && trade_ch.valid === 1'b1 && trade_ch.ready === 1'b1)
            book.check_trade('{taker_id:       trade_ch.taker_id,
                               maker_id:       trade_ch.maker_id,
                               matched_shares: trade_ch.matched_shares,
                               outcome:        trade_ch.outcome,
                               last:           trade_ch.last});
    end

    function automatic order_t make_order(input logic act, input logic buy,
                                          input logic [PRICE_W-1:0] lim,
                                          input logic [SHARE_W-1:0] qty,
                                          input logic [ID_W-1:0] id);
        order_t o;
        o.action       = act;
        o.buy_side     = buy;
        o.limit_price  = lim;
        o.order_shares = qty;
        o.order_id     = id;
        return o;
    endfunction

    // Mostly adds and matches priced around the level, with some wide values mixed in.
    function automatic order_t random_order(input logic [PRICE_W-1:0] level);
        order_t      o;
        int          pick;
        logic [31:0] wide;
        o.action   = ($urandom_range(99) < 55) ? ACT_ADD : ACT_MATCH;
        o.buy_side = 1'($urandom_range(1));
        pick = $urandom_range(9);
        if (pick < 4)
            o.limit_price = level;
        else if (pick < 6)
            o.limit_price = level + $urandom_range(2) - 1;
        else
            o.limit_price = $urandom;
        pick = $urandom_range(19);
        wide = $urandom;
        if (pick == 0)
            o.order_shares = '0;
        else if (pick < 3)
            o.order_shares = wide[SHARE_W-1:0];
        else if (pick < 6 && o.action == ACT_MATCH && book.volume <= {SHARE_W{1'b1}})
            o.order_shares = book.volume[SHARE_W-1:0];
        else
            o.order_shares = SHARE_W'($urandom_range(300, 1));
        o.order_id = $urandom;
        return o;
    endfunction

    task send_order(input order_t item);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            order_ch.valid <= 1'b0;
            @(negedge clk);
        end
        order_ch.valid        <= 1'b1;
        order_ch.action       <= item.action;
        order_ch.buy_side     <= item.buy_side;
        order_ch.limit_price  <= item.limit_price;
        order_ch.order_shares <= item.order_shares;
        order_ch.order_id     <= item.order_id;
        @(posedge clk);
        while (order_ch.ready !== 1'b1)
            @(posedge clk);
        book.note_order(item);
    endtask

    task wait_drained();
        @(negedge clk);
        order_ch.valid <= 1'b0;
        while (book.expected_trades.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task config_level(input logic [PRICE_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        book.level_price = value;
    endtask

    initial
    begin
        int                 sum;
        int                 p;
        int                 k;
        logic [PRICE_W-1:0] phase_level;
        book                  = new();
        cycle_count           = 0;
        hold_left             = 0;
        sender_idle_pct       = 0;
        receiver_stall_pct    = 0;
        cfg_we                = 1'b0;
        cfg_data              = '0;
        order_ch.valid        = 1'b0;
        order_ch.action       = ACT_ADD;
        order_ch.buy_side     = 1'b0;
        order_ch.limit_price  = '0;
        order_ch.order_shares = '0;
        order_ch.order_id     = '0;
        rst_n                 = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Level price is 0 out of reset.
        send_order(make_order(ACT_MATCH, 1'b1, '0, '0, 32'd1));
        send_order(make_order(ACT_MATCH, 1'b0, '1, 24'd10, 32'd2));
        send_order(make_order(ACT_MATCH, 1'b0, '0, '1, 32'd3));
        send_order(make_order(ACT_ADD, 1'b1, '1, '0, 32'd4));
        send_order(make_order(ACT_ADD, 1'b0, '0, '1, '1));
        send_order(make_order(ACT_ADD, 1'b1, '0, 24'd1, '0));
        send_order(make_order(ACT_MATCH, 1'b1, '0, '0, 32'd5));
        send_order(make_order(ACT_MATCH, 1'b1, '1, '1, 32'd6));
        send_order(make_order(ACT_MATCH, 1'b0, '0, 24'd5, 32'd7));
        // Fill the queue, overrun it, then take it all in one order.
        sum = 0;
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin
            send_order(make_order(ACT_ADD, 1'($urandom_range(1)), $urandom,
                                  SHARE_W'($urandom_range(1000, 1)), $urandom));
            sum = sum + book.rest_qty[(book.head + book.used - 1) % QUEUE_DEPTH];
        end
        send_order(make_order(ACT_ADD, 1'b0, '0, 24'd9, 32'd8));
        send_order(make_order(ACT_MATCH, 1'b1, '1, sum[SHARE_W-1:0], 32'd9));
        wait_drained();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: phase_level = '1;
                1: phase_level = '0;
                3: phase_level = 32'h8000_0000;
                default: phase_level = $urandom;
            endcase
            config_level(phase_level);
            case (p)
                1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
                3: begin sender_idle_pct = 6;  receiver_stall_pct = 6;  end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            // hold the trade side so the block backs up into the order side
            if (p == 0)
                hold_left = HOLD_CYCLES;
            for (k = 0; k < PHASE_ITEMS; k++)
                send_order(random_order(phase_level));
            wait_drained();
        end

        if (book.expected_trades.size() != 0)
            book.report_mismatch($sformatf("%0d trades never arrived",
                                           book.expected_trades.size()));
        if (book.mismatch_count == 0)
            $display("tb_price_level_order_matcher_top: done, clean");
        else
            $display("tb_price_level_order_matcher_top: done, errors");
        $finish;
    end

endmodule

// ===== price_level_order_matcher_top.f =====
rtl/plom_pkg.sv
rtl/plom_if.sv
rtl/plom_ctrl.sv
rtl/plom_dp.sv
rtl/price_level_order_matcher_top.sv
bench/tb_price_level_order_matcher_top.sv
